// ===== hdl/vmos_pkg.sv =====
// Shared types and constants for the operand stack block.
// Used by the controller, the datapath and the top level; depends on nothing.
package vmos_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 1024;
	localparam int ENTRY_W     = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = 11;
	localparam int MODE_W      = 3;
	localparam int COUNT_W     = 8;

	// Reset value of the capacity limit register
	localparam logic [DEPTH_W-1:0] LIMIT_RESET = 11'd1000;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COPY = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DROP = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SEEK = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SET  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_PEEK = 3'd6;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch the incoming request
		logic exec;     // decide, update state or start a memory read
		logic finish;   // complete a request that read the memory
	} vmos_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic rd_op;    // current request needs a memory read
		logic out_free; // result register can take a new result
	} vmos_stat_t;

endpackage

// ===== hdl/vm_operand_stack_top.sv =====
// Operand stack of a virtual machine with a settable capacity limit.
// Each request carries mode, value_in, position and drop_count on the input
// channel (in_valid / in_stall); each yields one result with ok, value_out
// and depth_out on the output channel (out_valid / out_stall).
// A request is taken when in_valid is high and in_stall low; in_stall is
// high while a request is in progress, so one request is handled at a time.
// Push, drop, seek, set and failed requests yield a valid result from the
// execute step; pop, peek and copy pass a further read step, since the
// single-port stack memory first reads and then (for copy) writes in the
// following cycle. The next request is accepted in the cycle the result
// appears, so a new request waits until the last one is through.
// The result register holds its payload while out_stall is high; a request
// that finishes meanwhile waits in its execute step until the register frees.
// cfg_wr_en / cfg_wr_data write the capacity limit; write it only when idle.
// Reset empties the stack (depth 0) and sets the limit to 1000; the memory
// itself is not cleared, and no legal request can read an unwritten entry.
// Depends on vmos_pkg, vmos_ctrl, vmos_dp and vmos_ram.
module vm_operand_stack_top
	import vmos_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ENTRY_W-1:0] value_in,
	input  logic [DEPTH_W-1:0] position,
	input  logic [COUNT_W-1:0] drop_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [ENTRY_W-1:0] value_out,
	output logic [DEPTH_W-1:0] depth_out,
	input  logic               cfg_wr_en,
	input  logic [DEPTH_W-1:0] cfg_wr_data
);

	vmos_cmd_t  cmd;
	vmos_stat_t stat;

	vmos_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	vmos_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.value_in   (value_in),
		.position   (position),
		.drop_count (drop_count),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.value_out  (value_out),
		.depth_out  (depth_out)
	);

	// Depth never exceeds the memory size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (depth_out <= DEPTH_W'(STACK_DEPTH)))
		else $error("depth beyond stack size");

	// A failed request reads nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (value_out == '0))
		else $error("failed request returned data");

	// An accepted request blocks the next one in the cycle that follows
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while busy");

endmodule

// ===== hdl/vmos_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; contents are undefined until written.
module vmos_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or read one word a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== hdl/vmos_ctrl.sv =====
// Controller state machine of the operand stack.
// Depends on vmos_pkg for the command and status types.
module vmos_ctrl
	import vmos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  vmos_stat_t stat,
	output vmos_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Take a request only when idle
	assign in_stall    = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC) && stat.out_free;
	assign cmd.finish  = (state_q == ST_READ);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.out_free) state_d = stat.rd_op ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/vmos_dp.sv =====
// Datapath of the operand stack: request latch, depth and limit registers,
// stack memory and result register. Depends on vmos_pkg and vmos_ram.
module vmos_dp
	import vmos_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  vmos_cmd_t          cmd,
	output vmos_stat_t         stat,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ENTRY_W-1:0] value_in,
	input  logic [DEPTH_W-1:0] position,
	input  logic [COUNT_W-1:0] drop_count,
	input  logic               cfg_wr_en,
	input  logic [DEPTH_W-1:0] cfg_wr_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [ENTRY_W-1:0] value_out,
	output logic [DEPTH_W-1:0] depth_out
);

	logic [MODE_W-1:0]  mode_q;
	logic [ENTRY_W-1:0] value_q;
	logic [DEPTH_W-1:0] pos_q;
	logic [COUNT_W-1:0] count_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [DEPTH_W-1:0] limit_q;
	logic               out_valid_q;
	logic               ok_q;
	logic [ENTRY_W-1:0] rd_value_q;
	logic [DEPTH_W-1:0] out_depth_q;

	logic               room;
	logic               op_ok;
	logic               rd_op;
	logic [DEPTH_W-1:0] depth_dec;
	logic [DEPTH_W-1:0] peek_idx;
	logic [DEPTH_W-1:0] depth_nxt;
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               load_out;
	logic               depth_upd;

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			value_q <= value_in;
			pos_q   <= position;
			count_q <= drop_count;
		end
	end

	// Capacity limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Decide success and the depth that follows
	assign room      = (depth_q < limit_q) && (depth_q < DEPTH_W'(STACK_DEPTH));
	assign depth_dec = depth_q - DEPTH_W'(1);
	assign peek_idx  = depth_dec - pos_q;

	always_comb begin
		op_ok     = 1'b0;
		rd_op     = 1'b0;
		depth_nxt = depth_q;
		case (mode_q)
			MODE_PUSH: begin
				op_ok     = room;
				depth_nxt = depth_q + DEPTH_W'(1);
			end
			MODE_POP: begin
				op_ok     = (depth_q != '0);
				rd_op     = op_ok;
				depth_nxt = depth_dec;
			end
			MODE_COPY: begin
				op_ok     = (pos_q < depth_q) && room;
				rd_op     = op_ok;
				depth_nxt = depth_q + DEPTH_W'(1);
			end
			MODE_DROP: begin
				op_ok     = (DEPTH_W'(count_q) <= depth_q);
				depth_nxt = depth_q - DEPTH_W'(count_q);
			end
			MODE_SEEK: begin
				op_ok     = (pos_q <= depth_q);
				depth_nxt = pos_q;
			end
			MODE_SET: begin
				op_ok = (pos_q < depth_q);
			end
			MODE_PEEK: begin
				op_ok = (pos_q < depth_q);
				rd_op = op_ok;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
		if (!op_ok) depth_nxt = depth_q;
	end

	assign stat.rd_op    = rd_op;
	assign stat.out_free = !out_valid_q || !out_stall;

	// Drive the memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = depth_q[ADDR_W-1:0];
		ram_wdata = value_q;
		if (cmd.finish) begin
			ram_we    = (mode_q == MODE_COPY);
			ram_wdata = ram_rdata;
		end else if (cmd.exec && op_ok) begin
			case (mode_q)
				MODE_PUSH: begin
					ram_we = 1'b1;
				end
				MODE_SET: begin
					ram_we   = 1'b1;
					ram_addr = pos_q[ADDR_W-1:0];
				end
				MODE_POP: begin
					ram_addr = depth_dec[ADDR_W-1:0];
				end
				MODE_PEEK: begin
					ram_addr = peek_idx[ADDR_W-1:0];
				end
				MODE_COPY: begin
					ram_addr = pos_q[ADDR_W-1:0];
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	vmos_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Update depth and load a result once a request completes
	assign load_out  = (cmd.exec && !rd_op) || cmd.finish;
	assign depth_upd = load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (depth_upd) begin
			depth_q <= depth_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			ok_q        <= op_ok;
			out_depth_q <= depth_nxt;
			if (cmd.finish && (mode_q != MODE_COPY)) begin
				rd_value_q <= ram_rdata;
			end else begin
				rd_value_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign value_out = rd_value_q;
	assign depth_out = out_depth_q;

endmodule
